FILE: src/vtl_pkg.sv
// Shared types, constants and classification functions for the token lexer.
package vtl_pkg;

    localparam int KW_COUNT = 20;
    localparam int KW_MAX_LEN = 9;

    typedef enum logic [2:0] {
        TK_END     = 3'd0,
        TK_NUMBER  = 3'd1,
        TK_IDENT   = 3'd2,
        TK_KEYWORD = 3'd3,
        TK_SYMBOL  = 3'd4
    } t_tok_kind;

    typedef enum logic [7:0] {
        M_IDLE   = 8'b0000_0001,
        M_NUMBER = 8'b0000_0010,
        M_IDENT  = 8'b0000_0100,
        M_SLASH  = 8'b0000_1000,
        M_SYM    = 8'b0001_0000,
        M_LINE   = 8'b0010_0000,
        M_BLOCK  = 8'b0100_0000,
        M_BSTAR  = 8'b1000_0000
    } t_mode;

    typedef logic [8*KW_MAX_LEN-1:0] t_kw_text;

    // Keyword text, first character in the low byte.
    function automatic t_kw_text kw_text(input logic [4:0] idx);
        t_kw_text t;
        t = '0;
        unique case (idx)
            5'd0:  t = t_kw_text'({"eludom"});
            5'd1:  t = t_kw_text'({"eludomdne"});
            5'd2:  t = t_kw_text'({"tupni"});
            5'd3:  t = t_kw_text'({"tuptuo"});
            5'd4:  t = t_kw_text'({"tuoni"});
            5'd5:  t = t_kw_text'({"ger"});
            5'd6:  t = t_kw_text'({"eriw"});
            5'd7:  t = t_kw_text'({"syawla"});
            5'd8:  t = t_kw_text'({"ngissa"});
            5'd9:  t = t_kw_text'({"egdesop"});
            5'd10: t = t_kw_text'({"egdegen"});
            5'd11: t = t_kw_text'({"nigeb"});
            5'd12: t = t_kw_text'({"dne"});
            5'd13: t = t_kw_text'({"fi"});
            5'd14: t = t_kw_text'({"esle"});
            5'd15: t = t_kw_text'({"retemarap"});
            5'd16: t = t_kw_text'({"ro"});
            5'd17: t = t_kw_text'({"esac"});
            5'd18: t = t_kw_text'({"esacdne"});
            5'd19: t = t_kw_text'({"tluafed"});
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [3:0] kw_len(input logic [4:0] idx);
        logic [3:0] l;
        unique case (idx)
            5'd0, 5'd3, 5'd7, 5'd8:           l = 4'd6;
            5'd1, 5'd15:                      l = 4'd9;
            5'd2, 5'd4, 5'd11:                l = 4'd5;
            5'd5, 5'd12:                      l = 4'd3;
            5'd6, 5'd14, 5'd17:               l = 4'd4;
            5'd9, 5'd10, 5'd18, 5'd19:        l = 4'd7;
            5'd13, 5'd16:                     l = 4'd2;
            default:                          l = 4'd0;
        endcase
        return l;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        logic [7:0] l;
        l = c | 8'h20;
        return ((l >= "a") && (l <= "z")) || (c == "_");
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == " ") || (c == 8'h0A) || (c == 8'h09) || (c == 8'h0D);
    endfunction

    function automatic logic starts_pair(input logic [7:0] c);
        return (c == "<") || (c == ">") || (c == "=") || (c == "!") ||
               (c == "&") || (c == "|");
    endfunction

    function automatic logic is_pair(input logic [7:0] p, input logic [7:0] c);
        return ((p == "<") && ((c == "=") || (c == "<"))) ||
               ((p == ">") && ((c == "=") || (c == ">"))) ||
               ((p == "=") && (c == "=")) || ((p == "!") && (c == "=")) ||
               ((p == "&") && (c == "&")) || ((p == "|") && (c == "|"));
    endfunction

endpackage

FILE: src/vtl_kw_match.sv
// Parallel keyword compare of the buffered identifier text.
module vtl_kw_match #(
    parameter int MAX_KEYWORD_CHARS = 9,
    parameter int LENGTH_BITS = 16
) (
    input  logic [MAX_KEYWORD_CHARS-1:0][7:0] i_text,
    input  logic [LENGTH_BITS-1:0]            i_len,
    output logic                              o_hit,
    output logic [4:0]                        o_index
);
    import vtl_pkg::*;

    logic [KW_COUNT-1:0] w_hit;

    always_comb begin
        for (int k = 0; k < KW_COUNT; k++) begin
            t_kw_text t;
            logic     eq;
            t  = kw_text(5'(k));
            eq = (i_len == LENGTH_BITS'(kw_len(5'(k))));
            for (int j = 0; j < KW_MAX_LEN; j++) begin
                if (4'(j) < kw_len(5'(k)) && i_text[j] != t[8*j +: 8]) begin
                    eq = 1'b0;
                end
            end
            w_hit[k] = eq;
        end
    end

    always_comb begin
        o_hit   = 1'b0;
        o_index = '0;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (w_hit[k]) begin
                o_hit   = 1'b1;
                o_index = 5'(k);
            end
        end
    end

endmodule

FILE: src/vtl_out_queue.sv
// Two-entry result queue holding up to two tokens per transfer.
module vtl_out_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [1:0]   i_push_n,
    input  logic [W-1:0] i_tok0,
    input  logic [W-1:0] i_tok1,
    output logic         o_room,
    output logic         o_valid,
    output logic [W-1:0] o_tok,
    input  logic         i_stall
);
    logic [1:0]   r_cnt, n_cnt;
    logic [W-1:0] r_q0, r_q1, n_q0, n_q1;
    logic         w_pop;

    assign w_pop   = (r_cnt != 2'd0) && !i_stall;
    assign o_valid = (r_cnt != 2'd0);
    assign o_tok   = r_q0;
    assign o_room  = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && w_pop);

    always_comb begin
        logic [W-1:0] a;
        logic [1:0]   base;
        n_q0 = r_q0;
        n_q1 = r_q1;
        a    = r_q1;
        base = r_cnt;
        if (w_pop) begin
            n_q0 = a;
            base = r_cnt - 2'd1;
        end
        if (i_push_n != 2'd0) begin
            if (base == 2'd0) begin
                n_q0 = i_tok0;
                n_q1 = i_tok1;
            end else begin
                n_q1 = i_tok0;
            end
        end
        n_cnt = base + i_push_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

endmodule

FILE: src/verilog_token_lexer.sv
// Top level of the streaming Verilog token lexer.
// Usage:
//   Input channel: i_valid/o_stall with i_kind and i_char_byte. Kind 0 is one
//   source byte, kind 1 ends the stream, flushes any pending token and emits
//   an end token, then offsets restart at zero.
//   Output channel: o_valid/i_stall with one token per transfer; o_last_of_run
//   marks the last token caused by one input item.
// A token is written into the registered result queue by the transfer that closes it.
// Throughput: one byte per cycle; the mode transition and the 20-way keyword
//   compare sit between the lexer state and a two-entry result queue. A byte
//   that yields two tokens raises o_stall for one cycle while the queue drains.
// An input byte yields up to two tokens; when the receiver stalls the queue
//   fills and o_stall rises until room for two tokens is free again.
// Reset: mode returns to idle, offset, start, length and held symbol clear,
//   the result queue empties.
module verilog_token_lexer #(
    parameter int MAX_KEYWORD_CHARS = 9,
    parameter int OFFSET_BITS = 32,
    parameter int LENGTH_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_kind,
    input  logic [7:0]             i_char_byte,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [2:0]             o_token_kind,
    output logic [4:0]             o_keyword_index,
    output logic [OFFSET_BITS-1:0] o_start_offset,
    output logic [LENGTH_BITS-1:0] o_token_length,
    output logic [7:0]             o_first_symbol_char,
    output logic [7:0]             o_second_symbol_char,
    output logic                   o_last_of_run
);
    import vtl_pkg::*;

    localparam int TW = 3 + 5 + OFFSET_BITS + LENGTH_BITS + 8 + 8 + 1;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    typedef struct packed {
        logic [2:0]             kind;
        logic [4:0]             kw;
        logic [OFFSET_BITS-1:0] start;
        logic [LENGTH_BITS-1:0] len;
        logic [7:0]             c1;
        logic [7:0]             c2;
        logic                   last;
    } t_tok;

    t_mode                                r_mode, n_mode;
    logic [OFFSET_BITS-1:0]               r_pos, n_pos, r_start, n_start;
    logic [LENGTH_BITS-1:0]               r_cnt, n_cnt;
    logic [MAX_KEYWORD_CHARS-1:0][7:0]    r_kbuf, n_kbuf;
    logic [7:0]                           r_pend, n_pend;

    logic       w_acc, w_room, w_kw_hit;
    logic [4:0] w_kw_idx;
    logic [1:0] w_n;
    t_tok       w_t0, w_t1, w_q;

    assign o_stall = !w_room;
    assign w_acc   = i_valid && w_room;

    vtl_kw_match #(
        .MAX_KEYWORD_CHARS(MAX_KEYWORD_CHARS),
        .LENGTH_BITS(LENGTH_BITS)
    ) u_kw (
        .i_text (r_kbuf),
        .i_len  (r_cnt),
        .o_hit  (w_kw_hit),
        .o_index(w_kw_idx)
    );

    function automatic t_tok mk(input t_tok_kind k, input logic [4:0] kw,
                                input logic [OFFSET_BITS-1:0] s,
                                input logic [LENGTH_BITS-1:0] l,
                                input logic [7:0] a, input logic [7:0] b);
        t_tok t;
        t.kind = k;
        t.kw = kw;
        t.start = s;
        t.len = l;
        t.c1 = a;
        t.c2 = b;
        t.last = 1'b0;
        return t;
    endfunction

    always_comb begin
        t_tok       pend_tok;
        logic       has_pend, idle_go;
        logic [7:0] c;
        c        = i_char_byte;
        n_mode   = r_mode;
        n_pos    = r_pos + OFFSET_BITS'(1);
        n_start  = r_start;
        n_cnt    = r_cnt;
        n_kbuf   = r_kbuf;
        n_pend   = r_pend;
        w_n      = 2'd0;
        w_t0     = mk(TK_END, 5'd0, r_start, r_cnt, 8'd0, 8'd0);
        w_t1     = w_t0;
        has_pend = 1'b0;
        idle_go  = 1'b0;
        pend_tok = w_t0;

        unique case (r_mode)
            M_NUMBER: begin
                has_pend = 1'b1;
                pend_tok = mk(TK_NUMBER, 5'd0, r_start, r_cnt, 8'd0, 8'd0);
            end
            M_IDENT: begin
                has_pend = 1'b1;
                if (w_kw_hit && r_cnt <= LENGTH_BITS'(MAX_KEYWORD_CHARS)) begin
                    pend_tok = mk(TK_KEYWORD, w_kw_idx, r_start, r_cnt, 8'd0, 8'd0);
                end else begin
                    pend_tok = mk(TK_IDENT, 5'd0, r_start, r_cnt, 8'd0, 8'd0);
                end
            end
            M_SLASH: begin
                has_pend = 1'b1;
                pend_tok = mk(TK_SYMBOL, 5'd0, r_start, LENGTH_BITS'(1), "/", 8'd0);
            end
            M_SYM: begin
                has_pend = 1'b1;
                pend_tok = mk(TK_SYMBOL, 5'd0, r_start, LENGTH_BITS'(1), r_pend, 8'd0);
            end
            default: has_pend = 1'b0;
        endcase

        if (i_kind) begin
            if (has_pend) begin
                w_t0 = pend_tok;
                w_t1 = mk(TK_END, 5'd0, r_pos, '0, 8'd0, 8'd0);
                w_n  = 2'd2;
            end else begin
                w_t0 = mk(TK_END, 5'd0, r_pos, '0, 8'd0, 8'd0);
                w_n  = 2'd1;
            end
            n_mode  = M_IDLE;
            n_pos   = '0;
            n_start = '0;
            n_cnt   = '0;
            n_pend  = '0;
        end else begin
            unique case (r_mode)
                M_NUMBER: begin
                    if (is_digit(c) || is_letter(c) || c == 8'h27) begin
                        if (r_cnt != LEN_MAX) n_cnt = r_cnt + LENGTH_BITS'(1);
                    end else begin
                        idle_go = 1'b1;
                    end
                end
                M_IDENT: begin
                    if (is_digit(c) || is_letter(c)) begin
                        for (int j = 0; j < MAX_KEYWORD_CHARS; j++) begin
                            if (r_cnt == LENGTH_BITS'(j)) n_kbuf[j] = c;
                        end
                        if (r_cnt != LEN_MAX) n_cnt = r_cnt + LENGTH_BITS'(1);
                    end else begin
                        idle_go = 1'b1;
                    end
                end
                M_SLASH: begin
                    if (c == "/") n_mode = M_LINE;
                    else if (c == "*") n_mode = M_BLOCK;
                    else idle_go = 1'b1;
                end
                M_SYM: begin
                    if (is_pair(r_pend, c)) begin
                        w_t0   = mk(TK_SYMBOL, 5'd0, r_start, LENGTH_BITS'(2), r_pend, c);
                        w_n    = 2'd1;
                        n_mode = M_IDLE;
                    end else begin
                        idle_go = 1'b1;
                    end
                end
                M_LINE:  if (c == 8'h0A) n_mode = M_IDLE;
                M_BLOCK: if (c == "*") n_mode = M_BSTAR;
                M_BSTAR: begin
                    if (c == "/") n_mode = M_IDLE;
                    else if (c != "*") n_mode = M_BLOCK;
                end
                default: idle_go = 1'b1;
            endcase

            if (idle_go) begin
                t_tok sym;
                sym = mk(TK_SYMBOL, 5'd0, r_pos, LENGTH_BITS'(1), c, 8'd0);
                n_mode = M_IDLE;
                if (has_pend) begin
                    w_t0 = pend_tok;
                    w_t1 = sym;
                    w_n  = 2'd1;
                end else begin
                    w_t0 = sym;
                end
                if (!is_space(c)) begin
                    n_start = r_pos;
                    if (c == "/") begin
                        n_mode = M_SLASH;
                    end else if (is_digit(c)) begin
                        n_mode = M_NUMBER;
                        n_cnt  = LENGTH_BITS'(1);
                    end else if (is_letter(c)) begin
                        n_mode    = M_IDENT;
                        n_cnt     = LENGTH_BITS'(1);
                        n_kbuf[0] = c;
                    end else if (starts_pair(c)) begin
                        n_mode = M_SYM;
                        n_pend = c;
                    end else begin
                        w_n = w_n + 2'd1;
                    end
                end
            end
        end

        if (w_n == 2'd1) w_t0.last = 1'b1;
        if (w_n == 2'd2) w_t1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_pos   <= '0;
            r_start <= '0;
            r_cnt   <= '0;
            r_pend  <= '0;
        end else if (w_acc) begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
        end
        if (w_acc) r_kbuf <= n_kbuf;
    end

    vtl_out_queue #(.W(TW)) u_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push_n(w_acc ? w_n : 2'd0),
        .i_tok0  (w_t0),
        .i_tok1  (w_t1),
        .o_room  (w_room),
        .o_valid (o_valid),
        .o_tok   (w_q),
        .i_stall (i_stall)
    );

    assign o_token_kind         = w_q.kind;
    assign o_keyword_index      = w_q.kw;
    assign o_start_offset       = w_q.start;
    assign o_token_length       = w_q.len;
    assign o_first_symbol_char  = w_q.c1;
    assign o_second_symbol_char = w_q.c2;
    assign o_last_of_run        = w_q.last;

endmodule

FILE: src/vtl_checker.sv
// Port-level checks of the token lexer, bound to the top level.
module vtl_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [2:0] o_token_kind,
    input logic       o_last_of_run,
    input logic [7:0] o_first_symbol_char
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_token_kind))
        else $error("output changed while stalled");
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_token_kind == 3'd0 |-> o_last_of_run)
        else $error("end token not last of run");
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_token_kind <= 3'd4)
        else $error("bad token kind");
    a_sym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_token_kind != 3'd4 |-> o_first_symbol_char == 8'd0)
        else $error("symbol char on non-symbol");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid && !o_stall)
        else $error("not empty after reset");
endmodule

bind verilog_token_lexer vtl_checker u_vtl_checker (.*);

FILE: verif/verilog_token_lexer_checker.sv
// Checker for the token lexer: predicts tokens per input transfer and compares results.
`timescale 1ns / 100ps

module verilog_token_lexer_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  logic        i_kind,
    input  logic [7:0]  i_char_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_token_kind,
    input  logic [4:0]  i_keyword_index,
    input  logic [31:0] i_start_offset,
    input  logic [15:0] i_token_length,
    input  logic [7:0]  i_first_symbol_char,
    input  logic [7:0]  i_second_symbol_char,
    input  logic        i_last_of_run,
    output int          o_errors,
    output int          o_pending
);
    import vtl_pkg::*;

    typedef struct packed {
        logic [2:0]  kind;
        logic [4:0]  kw;
        logic [31:0] start;
        logic [15:0] len;
        logic [7:0]  c1;
        logic [7:0]  c2;
        logic        last;
    } t_token;

    typedef enum logic [2:0] {
        S_IDLE, S_NUMBER, S_IDENT, S_SLASH, S_SYM, S_LINE, S_BLOCK, S_BSTAR
    } t_lex_state;

    t_token     token_q[$];
    t_lex_state lex_state;
    logic [31:0] pos, tok_start;
    logic [15:0] tok_len;
    logic [7:0]  kw_buf[KW_MAX_LEN];
    logic [7:0]  held_char;
    t_token      new_toks[$];

    assign o_pending = token_q.size();

    function automatic t_token mk(logic [2:0] k, logic [4:0] kw, logic [31:0] s,
                                  logic [15:0] l, logic [7:0] a, logic [7:0] b);
        t_token t;
        t = '{kind: k, kw: kw, start: s, len: l, c1: a, c2: b, last: 1'b0};
        return t;
    endfunction

    function automatic bit word_matches(string w);
        for (int i = 0; i < w.len(); i++)
            if (kw_buf[i] != w[i]) return 0;
        return 1;
    endfunction

    task automatic close_word();
        string words[KW_COUNT] = '{"module", "endmodule", "input", "output", "inout",
            "reg", "wire", "always", "assign", "posedge", "negedge", "begin", "end",
            "if", "else", "parameter", "or", "case", "endcase", "default"};
        if (tok_len <= KW_MAX_LEN)
            for (int i = 0; i < KW_COUNT; i++)
                if (words[i].len() == tok_len && word_matches(words[i])) begin
                    new_toks.push_back(mk(TK_KEYWORD, 5'(i), tok_start, tok_len, 0, 0));
                    return;
                end
        new_toks.push_back(mk(TK_IDENT, 0, tok_start, tok_len, 0, 0));
    endtask

    task automatic start_token(logic [7:0] c);
        lex_state = S_IDLE;
        if (is_space(c)) return;
        tok_start = pos;
        if (c == "/") lex_state = S_SLASH;
        else if (is_digit(c)) begin
            lex_state = S_NUMBER;
            tok_len = 1;
        end else if (is_letter(c)) begin
            lex_state = S_IDENT;
            tok_len = 1;
            kw_buf[0] = c;
        end else if (starts_pair(c)) begin
            lex_state = S_SYM;
            held_char = c;
        end else new_toks.push_back(mk(TK_SYMBOL, 0, pos, 1, c, 0));
    endtask

    task automatic clear_lexer();
        lex_state = S_IDLE;
        pos = 0;
        tok_start = 0;
        tok_len = 0;
        held_char = 0;
        foreach (kw_buf[i]) kw_buf[i] = 0;
    endtask

    task automatic lex_byte(logic kind, logic [7:0] c);
        new_toks = {};
        if (kind) begin
            case (lex_state)
                S_NUMBER: new_toks.push_back(mk(TK_NUMBER, 0, tok_start, tok_len, 0, 0));
                S_IDENT:  close_word();
                S_SLASH:  new_toks.push_back(mk(TK_SYMBOL, 0, tok_start, 1, "/", 0));
                S_SYM:    new_toks.push_back(mk(TK_SYMBOL, 0, tok_start, 1, held_char, 0));
                default: ;
            endcase
            new_toks.push_back(mk(TK_END, 0, pos, 0, 0, 0));
            clear_lexer();
        end else begin
            case (lex_state)
                S_NUMBER:
                    if (is_digit(c) || is_letter(c) || c == 8'h27) begin
                        if (tok_len != 16'hFFFF) tok_len++;
                    end else begin
                        new_toks.push_back(mk(TK_NUMBER, 0, tok_start, tok_len, 0, 0));
                        start_token(c);
                    end
                S_IDENT:
                    if (is_digit(c) || is_letter(c)) begin
                        if (tok_len < KW_MAX_LEN) kw_buf[tok_len] = c;
                        if (tok_len != 16'hFFFF) tok_len++;
                    end else begin
                        close_word();
                        start_token(c);
                    end
                S_SLASH:
                    if (c == "/") lex_state = S_LINE;
                    else if (c == "*") lex_state = S_BLOCK;
                    else begin
                        new_toks.push_back(mk(TK_SYMBOL, 0, tok_start, 1, "/", 0));
                        start_token(c);
                    end
                S_SYM:
                    if (is_pair(held_char, c)) begin
                        new_toks.push_back(mk(TK_SYMBOL, 0, tok_start, 2, held_char, c));
                        lex_state = S_IDLE;
                    end else begin
                        new_toks.push_back(mk(TK_SYMBOL, 0, tok_start, 1, held_char, 0));
                        start_token(c);
                    end
                S_LINE:  if (c == 8'h0A) lex_state = S_IDLE;
                S_BLOCK: if (c == "*") lex_state = S_BSTAR;
                S_BSTAR:
                    if (c == "/") lex_state = S_IDLE;
                    else if (c != "*") lex_state = S_BLOCK;
                default: start_token(c);
            endcase
            pos++;
        end
        if (new_toks.size() > 0) new_toks[new_toks.size() - 1].last = 1'b1;
        foreach (new_toks[i]) token_q.push_back(new_toks[i]);
    endtask

    always @(posedge i_clk) begin
        t_token got, exp_tok;
        if (!i_rst_n) begin
            token_q = {};
            clear_lexer();
            o_errors <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = '{kind: i_token_kind, kw: i_keyword_index, start: i_start_offset,
                        len: i_token_length, c1: i_first_symbol_char,
                        c2: i_second_symbol_char, last: i_last_of_run};
                if (token_q.size() == 0) begin
                    $display("%0t: unexpected token, actual %p", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_tok = token_q.pop_front();
                    if (got !== exp_tok) begin
                        $display("%0t: token mismatch, expected %p, actual %p",
                                 $time, exp_tok, got);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_valid && !i_stall_in) lex_byte(i_kind, i_char_byte);
        end
    end
endmodule

FILE: verif/verilog_token_lexer_test.sv
// Testbench top for the token lexer: drives byte streams and gives the verdict.
`timescale 1ns / 100ps

module verilog_token_lexer_test;
    logic        clk, rst_n, in_valid, in_stall, in_kind, out_valid, out_stall, last;
    logic [7:0]  in_char, c1, c2;
    logic [2:0]  tok_kind;
    logic [4:0]  kw_idx;
    logic [31:0] start_off;
    logic [15:0] tok_len;
    int          errors, pending;
    int          sent, stall_left;

    verilog_token_lexer u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_kind(in_kind), .i_char_byte(in_char), .o_valid(out_valid),
        .i_stall(out_stall), .o_token_kind(tok_kind), .o_keyword_index(kw_idx),
        .o_start_offset(start_off), .o_token_length(tok_len),
        .o_first_symbol_char(c1), .o_second_symbol_char(c2), .o_last_of_run(last)
    );

    verilog_token_lexer_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_stall_in(in_stall),
        .i_kind(in_kind), .i_char_byte(in_char), .i_out_valid(out_valid),
        .i_out_stall(out_stall), .i_token_kind(tok_kind), .i_keyword_index(kw_idx),
        .i_start_offset(start_off), .i_token_length(tok_len),
        .i_first_symbol_char(c1), .i_second_symbol_char(c2), .i_last_of_run(last),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial begin
        #2ms;
        $display("verilog_token_lexer_test: FAIL");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    logic stall_mode;
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_mode) begin
            if (stall_left == 0 && $urandom_range(0, 99) < 35) stall_left = gap_len();
            out_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
        end else begin
            out_stall <= 1'b0;
        end
    end

    task automatic send(logic k, logic [7:0] c);
        int g;
        g = gap_len();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_kind  <= k;
        in_char  <= c;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send(1'b0, s[i]);
    endtask

    function automatic string pick_piece();
        string p[] = '{"module", "endmodule", "input", "output", "inout", "reg", "wire",
            "always", "assign", "posedge", "negedge", "begin", "end", "if", "else",
            "parameter", "or", "case", "endcase", "default", "x_1", "Foo", "_q",
            "modules", "parameters", "8'hFf", "12", "<=", ">=", "==", "!=", "<<", ">>",
            "&&", "||", "<", ">", "=", "!", "&", "|", ";", "(", ")", "/", "*", " ",
            "\n", "\t", "\r", "// note\n", "/* c */", "/*/ x */", "/**/", "a+b"};
        return p[$urandom_range(0, p.size() - 1)];
    endfunction

    initial begin
        rst_n = 0;
        in_valid = 0;
        in_kind = 0;
        in_char = 0;
        stall_mode = 0;
        sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("module endmodule parameter<=a>>=b!c/d//x\n");
        send_text("9'z_ abcdefghij");
        send(1'b1, 8'h00);
        send(1'b0, 8'h00);
        send(1'b0, 8'hFF);
        send(1'b0, 8'h80);
        send_text("/*/");
        send(1'b1, 8'h00);
        send_text("<");
        send(1'b1, 8'h00);

        stall_mode = 1;
        while (sent < 840) begin
            if (sent > 400 && sent < 420) begin
                in_valid <= 1'b0;
                while (pending != 0) @(posedge clk);
            end
            case ($urandom_range(0, 9))
                0: send(1'b0, 8'($urandom_range(0, 255)));
                1: if ($urandom_range(0, 3) == 0) send(1'b1, 8'($urandom));
                   else send(1'b0, 8'h20);
                default: send_text(pick_piece());
            endcase
        end
        send(1'b1, 8'h00);

        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0) $display("verilog_token_lexer_test: PASS");
        else $display("verilog_token_lexer_test: FAIL");
        $finish;
    end
endmodule

FILE: sim.f
src/vtl_pkg.sv
src/vtl_kw_match.sv
src/vtl_out_queue.sv
src/verilog_token_lexer.sv
src/vtl_checker.sv
verif/verilog_token_lexer_checker.sv
verif/verilog_token_lexer_test.sv
